// ===== src/pgmap_pkg.sv =====
`timescale 1ns / 1ps

package pgmap_pkg;

    localparam int POOL_TABLES   = 64;
    localparam int MAX_RUN_PAGES = 64;

    localparam int LEVEL_BITS  = 9;
    localparam int TBL_W       = $clog2(POOL_TABLES);
    localparam int NF_W        = $clog2(POOL_TABLES + 1);
    localparam int ADDR_W      = TBL_W + LEVEL_BITS;
    localparam int STORE_DEPTH = POOL_TABLES << LEVEL_BITS;

    localparam int VPAGE_W = 36;
    localparam int PAGE_W  = 40;
    localparam int COUNT_W = 7;
    localparam int FLAGS_W = 32;
    localparam int ENTRY_W = 64;
    localparam int INDEX_W = 6;
    localparam int ALLOC_W = 2;
    localparam int LEVEL_W = 2;

    typedef enum logic [1:0] {
        ST_MAPPED   = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_NO_TABLE = 2'd2
    } status_t;

    function automatic logic [LEVEL_BITS-1:0] level_index(
        input logic [VPAGE_W-1:0] v,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [LEVEL_BITS-1:0] r;
        unique case (lvl)
            2'd0: r = v[35:27];
            2'd1: r = v[26:18];
            2'd2: r = v[17:9];
            2'd3: r = v[8:0];
        endcase
        return r;
    endfunction

endpackage

// ===== src/pgmap_ram.sv =====
`timescale 1ns / 1ps

module pgmap_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/four_level_page_table_mapper.sv =====
`timescale 1ns / 1ps

// Four-level page table mapper.
// Command channel: a transaction is taken when start is high and busy is low;
// virt_page, phys_page, page_count (saturated to MAX_RUN_PAGES) and flags
// are sampled then. Each page of the run walks the radix table and yields
// one result, shown for a single cycle with result_valid high; last marks
// the final result of the run. An error (leaf present, pool exhausted or a
// stale link) ends the run with that result.
// Config: cfg_we writes cfg_data into pool_base_page; write only while idle.
// Walk: the root read is issued first, then each page walks the four levels
// in turn, one read per level, set by the single read port of the table store
// (registered read). busy stays high throughout a run.
// A zero page_count gives no results and no busy time.
// Reset: the store is swept to zero, one entry per cycle, STORE_DEPTH
// entries (32768 with 64 pool tables), with busy high; the free table
// pointer resets to one and pool_base_page to zero.
// The receiver cannot stall: results are never held.
module four_level_page_table_mapper (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pgmap_pkg::VPAGE_W-1:0]  virt_page,
    input  logic [pgmap_pkg::PAGE_W-1:0]   phys_page,
    input  logic [pgmap_pkg::COUNT_W-1:0]  page_count,
    input  logic [pgmap_pkg::FLAGS_W-1:0]  flags,
    input  logic                           cfg_we,
    input  logic [pgmap_pkg::PAGE_W-1:0]   cfg_data,
    output logic                           result_valid,
    output logic [1:0]                     status,
    output logic [pgmap_pkg::INDEX_W-1:0]  page_index,
    output logic [pgmap_pkg::ENTRY_W-1:0]  entry_value,
    output logic [pgmap_pkg::ALLOC_W-1:0]  tables_allocated,
    output logic                           last
);

    import pgmap_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_WALK
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clear_addr_reg, clear_addr_next;
    logic [PAGE_W-1:0]    pool_base_reg;
    logic [NF_W-1:0]      next_free_reg, next_free_next;
    logic [VPAGE_W-1:0]   vpage_reg, vpage_next;
    logic [PAGE_W-1:0]    ppage_reg, ppage_next;
    logic [FLAGS_W-1:0]   flags_reg, flags_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   idx_reg, idx_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [TBL_W-1:0]     tbl_reg, tbl_next;
    logic [ALLOC_W-1:0]   alloc_reg, alloc_next;
    logic                 fwd_hit_reg, fwd_hit_next;
    logic [ENTRY_W-1:0]   fwd_data_reg;

    logic                 res_valid_reg, res_valid_next;
    status_t              res_status_reg, res_status_next;
    logic [INDEX_W-1:0]   res_index_reg, res_index_next;
    logic [ENTRY_W-1:0]   res_entry_reg, res_entry_next;
    logic [ALLOC_W-1:0]   res_alloc_reg, res_alloc_next;
    logic                 res_last_reg, res_last_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;

    logic [ENTRY_W-1:0]   ent;
    logic [PAGE_W-1:0]    off;
    logic                 off_ok;
    logic                 pool_empty;
    logic [LEVEL_BITS-1:0] idx_cur, idx_nxt;
    logic [VPAGE_W-1:0]   vpage_inc;
    logic [COUNT_W-1:0]   count_sat;
    logic [PAGE_W-1:0]    link_page;
    logic                 run_last;

    pgmap_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent        = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign off        = ent[51:12] - pool_base_reg;
    assign off_ok     = off < PAGE_W'(next_free_reg);
    assign pool_empty = next_free_reg == NF_W'(POOL_TABLES);
    assign idx_cur    = level_index(vpage_reg, level_reg);
    assign idx_nxt    = level_index(vpage_reg, level_reg + LEVEL_W'(1));
    assign vpage_inc  = vpage_reg + VPAGE_W'(1);
    assign count_sat  = (page_count > COUNT_W'(MAX_RUN_PAGES)) ?
                        COUNT_W'(MAX_RUN_PAGES) : page_count;
    assign link_page  = pool_base_reg + PAGE_W'(next_free_reg);
    assign run_last   = (idx_reg + COUNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        next_free_next  = next_free_reg;
        vpage_next      = vpage_reg;
        ppage_next      = ppage_reg;
        flags_next      = flags_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        level_next      = level_reg;
        tbl_next        = tbl_reg;
        alloc_next      = alloc_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_entry_next  = res_entry_reg;
        res_alloc_next  = res_alloc_reg;
        res_last_next   = res_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = {tbl_reg, idx_cur};
        ram_wdata       = '0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = clear_addr_reg;
                clear_addr_next = clear_addr_reg + ADDR_W'(1);
                if (clear_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    vpage_next = virt_page;
                    ppage_next = phys_page;
                    flags_next = flags;
                    count_next = count_sat;
                    idx_next   = '0;
                    level_next = '0;
                    tbl_next   = '0;
                    alloc_next = '0;
                    if (count_sat != '0)
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                ram_raddr  = {TBL_W'(0), idx_cur};
                state_next = S_WALK;
            end
            S_WALK:
            begin
                res_index_next = idx_reg[INDEX_W-1:0];
                res_alloc_next = alloc_reg;
                res_entry_next = '0;
                res_status_next = ST_MAPPED;
                if (level_reg != LEVEL_W'(3))
                begin
                    if (ent[0])
                    begin
                        if (off_ok)
                        begin
                            tbl_next   = off[TBL_W-1:0];
                            level_next = level_reg + LEVEL_W'(1);
                            ram_raddr  = {off[TBL_W-1:0], idx_nxt};
                        end
                        else
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = ST_NO_TABLE;
                        end
                    end
                    else if (!pool_empty)
                    begin
                        ram_we         = 1'b1;
                        ram_wdata      = {12'd0, link_page, 12'h001};
                        next_free_next = next_free_reg + NF_W'(1);
                        alloc_next     = alloc_reg + ALLOC_W'(1);
                        tbl_next       = next_free_reg[TBL_W-1:0];
                        level_next     = level_reg + LEVEL_W'(1);
                        ram_raddr      = {next_free_reg[TBL_W-1:0], idx_nxt};
                    end
                    else
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = ST_NO_TABLE;
                    end
                end
                else
                begin
                    res_valid_next = 1'b1;
                    if (ent[0])
                    begin
                        res_status_next = ST_PRESENT;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        ram_wdata      = {12'd0, ppage_reg, 12'd0} |
                                         {32'd0, flags_reg} | ENTRY_W'(1);
                        res_entry_next = ram_wdata;
                    end
                end

                if (res_valid_next)
                begin
                    res_last_next = (res_status_next != ST_MAPPED) || run_last;
                    if (res_last_next)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        vpage_next = vpage_inc;
                        ppage_next = ppage_reg + PAGE_W'(1);
                        idx_next   = idx_reg + COUNT_W'(1);
                        level_next = '0;
                        tbl_next   = '0;
                        alloc_next = '0;
                        ram_raddr  = {TBL_W'(0), level_index(vpage_inc, LEVEL_W'(0))};
                    end
                end
            end
        endcase
    end

    assign fwd_hit_next = ram_we && (ram_waddr == ram_raddr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clear_addr_reg <= '0;
            next_free_reg  <= NF_W'(1);
            pool_base_reg  <= '0;
            fwd_hit_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            next_free_reg  <= next_free_next;
            if (cfg_we)
            begin
                pool_base_reg <= cfg_data;
            end
            fwd_hit_reg    <= fwd_hit_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg   <= ram_wdata;
        vpage_reg      <= vpage_next;
        ppage_reg      <= ppage_next;
        flags_reg      <= flags_next;
        count_reg      <= count_next;
        idx_reg        <= idx_next;
        level_reg      <= level_next;
        tbl_reg        <= tbl_next;
        alloc_reg      <= alloc_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_entry_reg  <= res_entry_next;
        res_alloc_reg  <= res_alloc_next;
        res_last_reg   <= res_last_next;
    end

    assign busy             = state_reg != S_IDLE;
    assign result_valid     = res_valid_reg;
    assign status           = res_status_reg;
    assign page_index       = res_index_reg;
    assign entry_value      = res_entry_reg;
    assign tables_allocated = res_alloc_reg;
    assign last             = res_last_reg;

endmodule
